// File: src/dmdp_pkg.sv
// Shared constants and types for the dual-mode drive PID core.
// No dependencies; compiled first.
`default_nettype none

package dmdp_pkg;

    // Fixed register and state widths
    localparam int INTEG_W    = 32;
    localparam int GAIN_W     = 20;
    localparam int WIN_W      = 16;
    localparam int OFFS_W     = 7;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // Register map, word index (byte address = 4 * index)
    typedef enum logic [REG_IDX_W-1:0] {
        REG_TURN_MODE    = 3'd0,
        REG_GAIN_P       = 3'd1,
        REG_GAIN_I       = 3'd2,
        REG_GAIN_D       = 3'd3,
        REG_RESET_WINDOW = 3'd4,
        REG_WINDOW_EN    = 3'd5,
        REG_RIGHT_OFFSET = 3'd6
    } t_reg_idx;

    // Reset values
    localparam logic              RST_TURN_MODE    = 1'b1;
    localparam logic [GAIN_W-1:0] RST_GAIN_P       = 20'd10240;
    localparam logic [GAIN_W-1:0] RST_GAIN_I       = 20'd164;
    localparam logic [GAIN_W-1:0] RST_GAIN_D       = 20'd20480;
    localparam logic [WIN_W-1:0]  RST_RESET_WINDOW = 16'd10;
    localparam logic              RST_WINDOW_EN    = 1'b1;
    localparam logic [OFFS_W-1:0] RST_RIGHT_OFFSET = 7'd5;

endpackage

`default_nettype wire

// File: src/dmdp_in_if.sv
// Input channel of the drive PID core: setpoint and two sensor readings.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface dmdp_in_if #(
    parameter int SENSOR_WIDTH = 16
);
    logic                           valid;
    logic                           ready;
    logic signed [SENSOR_WIDTH-1:0] setpoint;
    logic signed [SENSOR_WIDTH-1:0] measure_a;
    logic signed [SENSOR_WIDTH-1:0] measure_b;

    modport source (output valid, output setpoint, output measure_a, output measure_b,
                    input ready);
    modport sink   (input valid, input setpoint, input measure_a, input measure_b,
                    output ready);
endinterface

`default_nettype wire

// File: src/dmdp_out_if.sv
// Result channel of the drive PID core: drive commands, error and clip flag.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface dmdp_out_if #(
    parameter int SENSOR_WIDTH = 16,
    parameter int DRIVE_WIDTH  = 8
);
    logic                           valid;
    logic                           ready;
    logic signed [DRIVE_WIDTH-1:0]  left_drive;
    logic signed [DRIVE_WIDTH-1:0]  right_drive;
    logic signed [SENSOR_WIDTH:0]   error_now;
    logic                           integral_clipped;

    modport source (output valid, output left_drive, output right_drive,
                    output error_now, output integral_clipped, input ready);
    modport sink   (input valid, input left_drive, input right_drive,
                    input error_now, input integral_clipped, output ready);
endinterface

`default_nettype wire

// File: src/dual_mode_drive_pid_core.sv
// Top level of the dual-mode drive PID core: APB register file and PID pipeline.
// Depends on dmdp_pkg, dmdp_in_if and dmdp_out_if.
//
// One PID step per transfer on the input channel, one result transfer per step, in order.
// The datapath is a four-stage pipeline (error, integral/derivative, gain multiplies,
// sum/scale/saturate); each step passes the stage A, B, C and D registers in turn and its
// result is presented from stage D; a new input is taken every cycle unless back-pressure stalls it.
// Every stage stalls independently, so the pipeline keeps filling
// while a finished result waits. The integral and previous-error state close their loop
// in the second stage alone, which is what allows one step per cycle. Registers sit at
// byte address 4*index and must only be written while no step is in flight.
`default_nettype none

module dual_mode_drive_pid_core #(
    parameter int SENSOR_WIDTH   = 16,
    parameter int GAIN_FRAC_BITS = 12,
    parameter int DRIVE_LIMIT    = 127
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    dmdp_in_if.sink                                 i_in,
    dmdp_out_if.source                              o_out,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [dmdp_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [dmdp_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [dmdp_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready
);

    localparam int SW     = SENSOR_WIDTH;
    localparam int ERR_W  = SW + 1;
    localparam int DER_W  = SW + 2;
    localparam int DRV_W  = $clog2(DRIVE_LIMIT + 1) + 1;
    localparam int GS_W   = dmdp_pkg::GAIN_W + 1;
    localparam int IW     = dmdp_pkg::INTEG_W;
    localparam int PP_W   = GS_W + ERR_W;
    localparam int PI_W   = GS_W + IW;
    localparam int PD_W   = GS_W + DER_W;
    localparam int RAW_W  = ((PI_W > PD_W) ? PI_W : PD_W) + 2;
    localparam int SUM_W  = ((ERR_W > IW) ? ERR_W : IW) + 1;
    localparam int MAG_W  = (ERR_W > dmdp_pkg::WIN_W) ? ERR_W : dmdp_pkg::WIN_W;
    localparam int SEL_HI = dmdp_pkg::REG_IDX_W + 1;

    localparam logic signed [RAW_W-1:0] LIM_P     = RAW_W'(DRIVE_LIMIT);
    localparam logic signed [RAW_W-1:0] LIM_N     = -LIM_P;
    localparam logic signed [RAW_W-1:0] FRAC_MASK = RAW_W'((64'd1 << GAIN_FRAC_BITS) - 64'd1);

    // ---------------------------------------------------------------- registers
    logic                               r_turn_mode;
    logic [dmdp_pkg::GAIN_W-1:0]        r_gain_p;
    logic [dmdp_pkg::GAIN_W-1:0]        r_gain_i;
    logic [dmdp_pkg::GAIN_W-1:0]        r_gain_d;
    logic [dmdp_pkg::WIN_W-1:0]         r_reset_window;
    logic                               r_window_en;
    logic [dmdp_pkg::OFFS_W-1:0]        r_right_offset;
    logic                               cfg_wr;
    dmdp_pkg::t_reg_idx                 cfg_sel;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = dmdp_pkg::t_reg_idx'(paddr[SEL_HI:2]);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_turn_mode    <= dmdp_pkg::RST_TURN_MODE;
            r_gain_p       <= dmdp_pkg::RST_GAIN_P;
            r_gain_i       <= dmdp_pkg::RST_GAIN_I;
            r_gain_d       <= dmdp_pkg::RST_GAIN_D;
            r_reset_window <= dmdp_pkg::RST_RESET_WINDOW;
            r_window_en    <= dmdp_pkg::RST_WINDOW_EN;
            r_right_offset <= dmdp_pkg::RST_RIGHT_OFFSET;
        end else if (cfg_wr) begin
            unique case (cfg_sel)
                dmdp_pkg::REG_TURN_MODE:    r_turn_mode    <= pwdata[0];
                dmdp_pkg::REG_GAIN_P:       r_gain_p       <= pwdata[dmdp_pkg::GAIN_W-1:0];
                dmdp_pkg::REG_GAIN_I:       r_gain_i       <= pwdata[dmdp_pkg::GAIN_W-1:0];
                dmdp_pkg::REG_GAIN_D:       r_gain_d       <= pwdata[dmdp_pkg::GAIN_W-1:0];
                dmdp_pkg::REG_RESET_WINDOW: r_reset_window <= pwdata[dmdp_pkg::WIN_W-1:0];
                dmdp_pkg::REG_WINDOW_EN:    r_window_en    <= pwdata[0];
                dmdp_pkg::REG_RIGHT_OFFSET: r_right_offset <= pwdata[dmdp_pkg::OFFS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (cfg_sel)
            dmdp_pkg::REG_TURN_MODE:    prdata = dmdp_pkg::APB_DATA_W'(r_turn_mode);
            dmdp_pkg::REG_GAIN_P:       prdata = dmdp_pkg::APB_DATA_W'(r_gain_p);
            dmdp_pkg::REG_GAIN_I:       prdata = dmdp_pkg::APB_DATA_W'(r_gain_i);
            dmdp_pkg::REG_GAIN_D:       prdata = dmdp_pkg::APB_DATA_W'(r_gain_d);
            dmdp_pkg::REG_RESET_WINDOW: prdata = dmdp_pkg::APB_DATA_W'(r_reset_window);
            dmdp_pkg::REG_WINDOW_EN:    prdata = dmdp_pkg::APB_DATA_W'(r_window_en);
            dmdp_pkg::REG_RIGHT_OFFSET: prdata = dmdp_pkg::APB_DATA_W'(r_right_offset);
            default:                    prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------- handshake
    logic r_vld_a, r_vld_b, r_vld_c, r_vld_d;
    logic rdy_b, rdy_c, rdy_d;
    logic mv_a, mv_b, mv_c, mv_d;

    assign rdy_d      = !r_vld_d || o_out.ready;
    assign rdy_c      = !r_vld_c || rdy_d;
    assign rdy_b      = !r_vld_b || rdy_c;
    assign i_in.ready = !r_vld_a || rdy_b;
    assign mv_a       = i_in.valid && i_in.ready;
    assign mv_b       = r_vld_a && rdy_b;
    assign mv_c       = r_vld_b && rdy_c;
    assign mv_d       = r_vld_c && rdy_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
        end else begin
            if (i_in.ready) r_vld_a <= i_in.valid;
            if (rdy_b)      r_vld_b <= r_vld_a;
            if (rdy_c)      r_vld_c <= r_vld_b;
            if (rdy_d)      r_vld_d <= r_vld_c;
        end
    end

    // ---------------------------------------------------------------- stage A: error
    logic signed [ERR_W-1:0] sum_ab;
    logic signed [ERR_W-1:0] half_adj;
    logic signed [SW-1:0]    meas;
    logic signed [ERR_W-1:0] n_err;
    logic signed [ERR_W-1:0] r_err_a;

    always_comb begin
        sum_ab   = {i_in.measure_a[SW-1], i_in.measure_a}
                 + {i_in.measure_b[SW-1], i_in.measure_b};
        // bias negative sums by one so the halving truncates toward zero
        half_adj = sum_ab + ERR_W'(sum_ab[ERR_W-1]);
        meas     = r_turn_mode ? i_in.measure_a : half_adj[SW:1];
        n_err    = {i_in.setpoint[SW-1], i_in.setpoint} - {meas[SW-1], meas};
    end

    always_ff @(posedge i_clk) begin
        if (mv_a) r_err_a <= n_err;
    end

    // ---------------------------------------------------------------- stage B: I and D
    logic signed [IW-1:0]    r_integ;
    logic signed [ERR_W-1:0] r_prev;
    logic signed [SUM_W-1:0] isum;
    logic [SUM_W-IW:0]       isum_top;
    logic                    n_clip;
    logic signed [IW-1:0]    isat;
    logic [ERR_W-1:0]        mag;
    logic                    win_clr;
    logic signed [IW-1:0]    n_integ;
    logic signed [DER_W-1:0] n_deriv;

    logic signed [ERR_W-1:0] r_err_b;
    logic signed [IW-1:0]    r_isum_b;
    logic signed [DER_W-1:0] r_deriv_b;
    logic                    r_clip_b;

    always_comb begin
        isum     = SUM_W'(r_integ) + SUM_W'(r_err_a);
        isum_top = isum[SUM_W-1:IW-1];
        n_clip   = !((&isum_top) || !(|isum_top));
        if (n_clip) begin
            isat = isum[SUM_W-1] ? {1'b1, {(IW-1){1'b0}}} : {1'b0, {(IW-1){1'b1}}};
        end else begin
            isat = isum[IW-1:0];
        end
        mag      = r_err_a[ERR_W-1] ? ERR_W'(-r_err_a) : ERR_W'(r_err_a);
        win_clr  = r_window_en && (MAG_W'(mag) > MAG_W'(r_reset_window));
        n_integ  = win_clr ? '0 : isat;
        n_deriv  = {r_err_a[ERR_W-1], r_err_a} - {r_prev[ERR_W-1], r_prev};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
        end else if (mv_b) begin
            r_integ <= n_integ;
            r_prev  <= r_err_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mv_b) begin
            r_err_b   <= r_err_a;
            r_isum_b  <= n_integ;
            r_deriv_b <= n_deriv;
            r_clip_b  <= n_clip;
        end
    end

    // ---------------------------------------------------------------- stage C: gains
    logic signed [PP_W-1:0]  n_pp;
    logic signed [PI_W-1:0]  n_pi;
    logic signed [PD_W-1:0]  n_pd;
    logic signed [PP_W-1:0]  r_pp_c;
    logic signed [PI_W-1:0]  r_pi_c;
    logic signed [PD_W-1:0]  r_pd_c;
    logic signed [ERR_W-1:0] r_err_c;
    logic                    r_clip_c;

    always_comb begin
        n_pp = $signed({1'b0, r_gain_p}) * r_err_b;
        n_pi = $signed({1'b0, r_gain_i}) * r_isum_b;
        n_pd = $signed({1'b0, r_gain_d}) * r_deriv_b;
    end

    always_ff @(posedge i_clk) begin
        if (mv_c) begin
            r_pp_c   <= n_pp;
            r_pi_c   <= n_pi;
            r_pd_c   <= n_pd;
            r_err_c  <= r_err_b;
            r_clip_c <= r_clip_b;
        end
    end

    // ---------------------------------------------------------------- stage D: output
    function automatic logic signed [DRV_W-1:0] f_clamp(input logic signed [RAW_W-1:0] v);
        logic signed [DRV_W-1:0] res;
        if (v > LIM_P) begin
            res = DRV_W'(LIM_P);
        end else if (v < LIM_N) begin
            res = DRV_W'(LIM_N);
        end else begin
            res = DRV_W'(v);
        end
        return res;
    endfunction

    logic signed [RAW_W-1:0] raw;
    logic signed [RAW_W-1:0] raw_adj;
    logic signed [RAW_W-1:0] speed_q;
    logic signed [RAW_W-1:0] right_q;
    logic signed [DRV_W-1:0] n_left;
    logic signed [DRV_W-1:0] n_right;

    logic signed [DRV_W-1:0] r_left;
    logic signed [DRV_W-1:0] r_right;
    logic signed [ERR_W-1:0] r_err_d;
    logic                    r_clip_d;

    always_comb begin
        raw     = RAW_W'(r_pp_c) + RAW_W'(r_pi_c) + RAW_W'(r_pd_c);
        // truncate toward zero when dropping the fraction
        raw_adj = raw + (raw[RAW_W-1] ? FRAC_MASK : '0);
        speed_q = raw_adj >>> GAIN_FRAC_BITS;
        right_q = speed_q - $signed(RAW_W'(r_right_offset));
        n_left  = f_clamp(speed_q);
        n_right = r_turn_mode ? -n_left : f_clamp(right_q);
    end

    always_ff @(posedge i_clk) begin
        if (mv_d) begin
            r_left   <= n_left;
            r_right  <= n_right;
            r_err_d  <= r_err_c;
            r_clip_d <= r_clip_c;
        end
    end

    assign o_out.valid            = r_vld_d;
    assign o_out.left_drive       = r_left;
    assign o_out.right_drive      = r_right;
    assign o_out.error_now        = r_err_d;
    assign o_out.integral_clipped = r_clip_d;

endmodule

`default_nettype wire
